[rtl/asf_pkg.sv]
// Package for the anchored spring force block.
// Holds widths, reset values, register indexes and the item types.
// Used by every module of the block; depends on nothing.
package asf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned AD_W      = POS_W + 1;
  localparam int unsigned LEN_W     = AD_W + 1;
  localparam int unsigned K_W       = 31;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned CFG_W     = 32;

  localparam logic [K_W-1:0] STIFF_RESET = K_W'(65536);

  typedef enum logic [1:0] {
    REG_ANCHOR_X  = 2'd0,
    REG_ANCHOR_Y  = 2'd1,
    REG_STIFFNESS = 2'd2,
    REG_REST_LEN  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] force_x;
    logic signed [Q_W-1:0] force_y;
    logic                  saturated;
  } out_item_t;

endpackage

[rtl/anchored_spring_force.sv]
// Anchored spring force: a pipeline of offset, squares, 34 square root
// cells, three multiply stages, 32 division cells, output register.
// Throughput one item per cycle while the output is not stalled.
// The whole pipeline advances together and holds while a result waits.
// Reset clears all valid bits and loads the register reset values.
module anchored_spring_force import asf_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned SqSteps = LEN_W;
  localparam int unsigned MagW    = K_W + LEN_W - FracBits;
  localparam int unsigned NW      = MagW + AD_W;
  localparam int unsigned SqSideW = 2 + 2 * AD_W;
  localparam int unsigned DvSideW = 5;

  logic                    adv;
  logic [POS_W-1:0]        anchor_x_q, anchor_y_q;
  logic [K_W-1:0]          stiff_q, rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      stiff_q    <= STIFF_RESET;
      rest_q     <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ANCHOR_X:  anchor_x_q <= cfg_data_i[POS_W-1:0];
        REG_ANCHOR_Y:  anchor_y_q <= cfg_data_i[POS_W-1:0];
        REG_STIFFNESS: stiff_q    <= cfg_data_i[K_W-1:0];
        REG_REST_LEN:  rest_q     <= cfg_data_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Offset from the anchor.
  logic [AD_W-1:0] dx, dy;
  logic            p0_vld_q, p0_negx_q, p0_negy_q;
  logic [AD_W-1:0] p0_adx_q, p0_ady_q;

  always_comb begin
    dx = {in_i.pos_x[POS_W-1], in_i.pos_x} - {anchor_x_q[POS_W-1], anchor_x_q};
    dy = {in_i.pos_y[POS_W-1], in_i.pos_y} - {anchor_y_q[POS_W-1], anchor_y_q};
  end

  // Squared length.
  logic                 p1_vld_q;
  logic [2*AD_W-1:0]    p1_sum_q;
  logic [SqSideW-1:0]   p1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
    end else if (adv) begin
      p0_vld_q <= in_valid_i;
      p1_vld_q <= p0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_negx_q <= dx[AD_W-1];
      p0_negy_q <= dy[AD_W-1];
      p0_adx_q  <= dx[AD_W-1] ? (~dx + AD_W'(1)) : dx;
      p0_ady_q  <= dy[AD_W-1] ? (~dy + AD_W'(1)) : dy;
      p1_sum_q  <= p0_adx_q * p0_adx_q + p0_ady_q * p0_ady_q;
      p1_side_q <= {p0_negx_q, p0_negy_q, p0_adx_q, p0_ady_q};
    end
  end

  // Square root chain.
  logic                     sq_vld  [SqSteps+1];
  logic [2*SqSteps-1:0]     sq_rad  [SqSteps+1];
  logic [SqSteps+1:0]       sq_rem  [SqSteps+1];
  logic [SqSteps-1:0]       sq_root [SqSteps+1];
  logic [SqSideW-1:0]       sq_side [SqSteps+1];

  assign sq_vld[0]  = p1_vld_q;
  assign sq_rad[0]  = {{(2*SqSteps-2*AD_W){1'b0}}, p1_sum_q};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = p1_side_q;

  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    asf_sqrt_cell #(
      .RootW (SqSteps),
      .SideW (SqSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (sq_vld[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // Magnitude, products and division setup.
  logic [LEN_W-1:0]         len, diff;
  logic [K_W+LEN_W-1:0]     prod;
  logic                     m1_vld_q, m2_vld_q, m3_vld_q;
  logic [MagW-1:0]          m1_mag_q;
  logic [LEN_W-1:0]         m1_len_q, m2_len_q, m3_len_q;
  logic                     m1_z_q, m2_z_q, m3_z_q;
  logic [1:0]               m1_neg_q, m2_neg_q, m3_neg_q, m3_ovf_q;
  logic [1:0][AD_W-1:0]     m1_ad_q;
  logic [1:0][32+AD_W-1:0]  m2_lo_q;
  logic [1:0][MagW-32+AD_W-1:0] m2_hi_q;
  logic [1:0][NW-1:0]       nsum;
  logic [1:0][LEN_W-1:0]    m3_rem_q;
  logic [1:0][Q_W-1:0]      m3_num_q;

  always_comb begin
    len  = sq_root[SqSteps];
    diff = (len >= LEN_W'(rest_q)) ? len - LEN_W'(rest_q) : LEN_W'(rest_q) - len;
    prod = stiff_q * diff;
    for (int l = 0; l < 2; l++) begin
      nsum[l] = {m2_hi_q[l], 32'd0} + NW'(m2_lo_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= sq_vld[SqSteps];
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_mag_q   <= prod[MagW+FracBits-1:FracBits];
      m1_len_q   <= len;
      m1_z_q     <= (len == '0);
      m1_neg_q   <= sq_side[SqSteps][SqSideW-1 -: 2];
      m1_ad_q[0] <= sq_side[SqSteps][2*AD_W-1:AD_W];
      m1_ad_q[1] <= sq_side[SqSteps][AD_W-1:0];
      for (int l = 0; l < 2; l++) begin
        m2_lo_q[l] <= m1_mag_q[31:0] * m1_ad_q[l];
        m2_hi_q[l] <= m1_mag_q[MagW-1:32] * m1_ad_q[l];
        m3_ovf_q[l] <= (nsum[l][NW-1:32] >= {{(NW-32-LEN_W){1'b0}}, m2_len_q});
        m3_rem_q[l] <= nsum[l][32+LEN_W-1:32];
        m3_num_q[l] <= nsum[l][Q_W-1:0];
      end
      m2_len_q <= m1_len_q;
      m2_z_q   <= m1_z_q;
      m2_neg_q <= m1_neg_q;
      m3_len_q <= m2_len_q;
      m3_z_q   <= m2_z_q;
      m3_neg_q <= m2_neg_q;
    end
  end

  // Division chain.
  logic                       dv_vld  [Q_W+1];
  logic [LEN_W-1:0]           dv_den  [Q_W+1];
  logic [1:0][LEN_W-1:0]      dv_rem  [Q_W+1];
  logic [1:0][Q_W-1:0]        dv_num  [Q_W+1];
  logic [1:0][Q_W-1:0]        dv_quo  [Q_W+1];
  logic [DvSideW-1:0]         dv_side [Q_W+1];

  assign dv_vld[0]  = m3_vld_q;
  assign dv_den[0]  = m3_len_q;
  assign dv_rem[0]  = m3_rem_q;
  assign dv_num[0]  = m3_num_q;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = {m3_z_q, m3_ovf_q, m3_neg_q};

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    asf_div_cell #(
      .LenW  (LEN_W),
      .NumW  (Q_W),
      .SideW (DvSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (dv_vld[i]),
      .den_i  (dv_den[i]),
      .rem_i  (dv_rem[i]),
      .num_i  (dv_num[i]),
      .quo_i  (dv_quo[i]),
      .side_i (dv_side[i]),
      .vld_o  (dv_vld[i+1]),
      .den_o  (dv_den[i+1]),
      .rem_o  (dv_rem[i+1]),
      .num_o  (dv_num[i+1]),
      .quo_o  (dv_quo[i+1]),
      .side_o (dv_side[i+1])
    );
  end

  // Sign and saturation.
  logic [1:0][Q_W-1:0] res;
  logic [1:0]          sat;
  logic                f_z;
  logic [1:0]          f_ovf, f_neg;
  logic [Q_W-1:0]      q;
  out_item_t           out_q;

  always_comb begin
    f_z   = dv_side[Q_W][4];
    f_ovf = dv_side[Q_W][3:2];
    f_neg = dv_side[Q_W][1:0];
    res   = '0;
    sat   = '0;
    q     = '0;
    for (int l = 0; l < 2; l++) begin
      q = dv_quo[Q_W][l];
      if (f_z) begin
        res[l] = '0;
      end else if (f_neg[1-l]) begin
        if (f_ovf[l] || q[Q_W-1]) begin
          sat[l] = 1'b1;
          res[l] = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          res[l] = q;
        end
      end else begin
        if (f_ovf[l] || (q > {1'b1, {(Q_W-1){1'b0}}})) begin
          sat[l] = 1'b1;
          res[l] = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          res[l] = ~q + Q_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.force_x   <= res[0];
      out_q.force_y   <= res[1];
      out_q.saturated <= |sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

[rtl/asf_sqrt_cell.sv]
// One digit cell of the pipelined integer square root chain.
// Resolves one root bit per enabled cycle, passes side data; uses asf_pkg.
module asf_sqrt_cell import asf_pkg::*; #(
  parameter int unsigned RootW = LEN_W,
  parameter int unsigned SideW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [2*RootW-1:0]   rad_i,
  input  logic [RootW+1:0]     rem_i,
  input  logic [RootW-1:0]     root_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 vld_o,
  output logic [2*RootW-1:0]   rad_o,
  output logic [RootW+1:0]     rem_o,
  output logic [RootW-1:0]     root_o,
  output logic [SideW-1:0]     side_o
);

  logic [RootW+3:0]   rem2, trial, sub;
  logic               ge;
  logic               vld_q;
  logic [2*RootW-1:0] rad_q, rad_d;
  logic [RootW+1:0]   rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [SideW-1:0]   side_q;

  always_comb begin
    rem2   = {rem_i, rad_i[2*RootW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = (rem2 >= trial);
    sub    = rem2 - trial;
    rem_d  = ge ? sub[RootW+1:0] : rem2[RootW+1:0];
    root_d = {root_i[RootW-2:0], ge};
    rad_d  = {rad_i[2*RootW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

[rtl/asf_div_cell.sv]
// One restoring division cell for both force lanes.
// One quotient bit per lane per enabled cycle; uses asf_pkg.
module asf_div_cell import asf_pkg::*; #(
  parameter int unsigned LenW  = LEN_W,
  parameter int unsigned NumW  = Q_W,
  parameter int unsigned SideW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [LenW-1:0]       den_i,
  input  logic [1:0][LenW-1:0]  rem_i,
  input  logic [1:0][NumW-1:0]  num_i,
  input  logic [1:0][NumW-1:0]  quo_i,
  input  logic [SideW-1:0]      side_i,
  output logic                  vld_o,
  output logic [LenW-1:0]       den_o,
  output logic [1:0][LenW-1:0]  rem_o,
  output logic [1:0][NumW-1:0]  num_o,
  output logic [1:0][NumW-1:0]  quo_o,
  output logic [SideW-1:0]      side_o
);

  logic [LenW:0]              r2, sub;
  logic                       ge;
  logic [1:0][LenW-1:0]       rem_d, rem_q;
  logic [1:0][NumW-1:0]       num_d, num_q, quo_d, quo_q;
  logic                       vld_q;
  logic [LenW-1:0]            den_q;
  logic [SideW-1:0]           side_q;

  always_comb begin
    r2    = '0;
    sub   = '0;
    ge    = 1'b0;
    rem_d = '0;
    num_d = '0;
    quo_d = '0;
    for (int l = 0; l < 2; l++) begin
      r2       = {rem_i[l], num_i[l][NumW-1]};
      ge       = (r2 >= {1'b0, den_i});
      sub      = r2 - {1'b0, den_i};
      rem_d[l] = ge ? sub[LenW-1:0] : r2[LenW-1:0];
      num_d[l] = {num_i[l][NumW-2:0], 1'b0};
      quo_d[l] = {quo_i[l][NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      num_q  <= num_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign quo_o  = quo_q;
  assign side_o = side_q;

endmodule

[tb/anchored_spring_force_test.sv]
// Testbench for the anchored spring force block: random and directed body
// positions under several register settings, checked against a predictor.
// Depends on asf_pkg and the anchored_spring_force top level.
module anchored_spring_force_test;
  import asf_pkg::*;

  localparam int unsigned DrainCycles = 100;
  localparam int unsigned WatchLimit  = 20000;

  class force_scoreboard;
    logic [POS_W-1:0] anc_x, anc_y;
    logic [K_W-1:0]   stiff, rest;
    out_item_t        pending[$];
    int unsigned      errors;

    function new();
      anc_x = '0;
      anc_y = '0;
      stiff = STIFF_RESET;
      rest  = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_ANCHOR_X:  anc_x = v;
        REG_ANCHOR_Y:  anc_y = v;
        REG_STIFFNESS: stiff = v[K_W-1:0];
        REG_REST_LEN:  rest  = v[K_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] axis_force(logic signed [32:0] d, logic [63:0] mag,
                                     logic [33:0] len, inout logic sat);
      logic [32:0]  ad;
      logic [127:0] num;
      logic [63:0]  q;
      if (d == 0) return '0;
      ad  = d[32] ? 33'(-d) : 33'(d);
      num = 128'(mag) * 128'(ad);
      q   = 64'(num / 128'(len));
      if (!d[32]) begin
        if (q > 64'h8000_0000) begin
          sat = 1'b1;
          return 32'h8000_0000;
        end
        return 32'(64'd0 - q);
      end
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    endfunction

    function void note_input(in_item_t it);
      logic signed [32:0] dx, dy;
      logic [32:0] adx, ady;
      logic [67:0] sum;
      logic [33:0] len, c, diff;
      logic [63:0] prod, mag;
      logic        sat;
      out_item_t   r;
      dx  = {it.pos_x[31], it.pos_x} - {anc_x[31], anc_x};
      dy  = {it.pos_y[31], it.pos_y} - {anc_y[31], anc_y};
      adx = dx[32] ? 33'(-dx) : 33'(dx);
      ady = dy[32] ? 33'(-dy) : 33'(dy);
      sum = 68'(adx) * 68'(adx) + 68'(ady) * 68'(ady);
      len = '0;
      for (int b = 33; b >= 0; b--) begin
        c = len | (34'd1 << b);
        if (68'(c) * 68'(c) <= sum) len = c;
      end
      r = '0;
      if (len != 0) begin
        diff = (len >= 34'(rest)) ? len - 34'(rest) : 34'(rest) - len;
        prod = 64'(stiff) * 64'(diff);
        mag  = prod >> FRAC_BITS;
        sat  = 1'b0;
        r.force_x   = axis_force(dx, mag, len, sat);
        r.force_y   = axis_force(dy, mag, len, sat);
        r.saturated = sat;
      end
      pending.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item %h", got));
        return;
      end
      exp = pending.pop_front();
      if (got.force_x !== exp.force_x)
        report($sformatf("force_x got %h exp %h", got.force_x, exp.force_x));
      if (got.force_y !== exp.force_y)
        report($sformatf("force_y got %h exp %h", got.force_y, exp.force_y));
      if (got.saturated !== exp.saturated)
        report($sformatf("saturated got %b exp %b", got.saturated, exp.saturated));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  force_scoreboard sb = new();
  int unsigned     idle_cycles = 0;

  always #2 clk = ~clk;

  anchored_spring_force u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk) begin
    if (in_valid && in_ready) sb.note_input(in_item);
    if (out_valid && out_ready) sb.check_result(out_item);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_cfg(reg_idx_e idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_spring(logic [31:0] ax, logic [31:0] ay, logic [31:0] k,
                            logic [31:0] rl);
    drain();
    write_cfg(REG_ANCHOR_X, ax);
    write_cfg(REG_ANCHOR_Y, ay);
    write_cfg(REG_STIFFNESS, k);
    write_cfg(REG_REST_LEN, rl);
  endtask

  int unsigned burst_left = 0;

  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] anc);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return anc + 32'($signed($urandom_range(0, 8)) - 4);
      2: return anc + 32'($signed($urandom_range(0, 2000000)) - 1000000);
      3: return anc;
      4: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return anc + (32'($urandom()) >>> $urandom_range(0, 31));
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.pos_x = rand_coord(sb.anc_x);
      it.pos_y = rand_coord(sb.anc_y);
      send_item(it);
    end
  endtask

  task automatic send_directed();
    logic [31:0] vals[6];
    in_item_t    it;
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 3; j++) begin
        it.pos_x = vals[i];
        it.pos_y = vals[(i + j * 2) % 6];
        send_item(it);
      end
    end
    it.pos_x = sb.anc_x;
    it.pos_y = sb.anc_y;
    send_item(it);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    send_random(60);
    stop_sending();
    while (sb.pending.size() != 0) @(posedge clk);
    send_random(40);
    stop_sending();
    set_spring(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_directed();
    send_random(80);
    stop_sending();
    set_spring(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_random(60);
    stop_sending();
    set_spring(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    send_directed();
    send_random(80);
    stop_sending();
    for (int p = 0; p < 5; p++) begin
      set_spring($urandom(), $urandom(), $urandom() >> $urandom_range(1, 16),
                 $urandom() >> $urandom_range(1, 16));
      send_random(70);
      stop_sending();
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/asf_pkg.sv
rtl/asf_sqrt_cell.sv
rtl/asf_div_cell.sv
rtl/anchored_spring_force.sv
tb/anchored_spring_force_test.sv
